/* rtl/core/fibmod_pkg.sv */
// ----------------------------------------------------------------------------
// fibmod_pkg
// Types, widths and the modular add helper shared by the Fibonacci modulo
// core and its modular multiply unit.
// ----------------------------------------------------------------------------
package fibmod_pkg;

    localparam int INDEX_BITS = 48;
    localparam int MOD_BITS   = 20;

    // bit position counters
    localparam int IDX_W = $clog2(INDEX_BITS);
    localparam int CNT_W = $clog2(MOD_BITS);

    typedef logic [INDEX_BITS-1:0] index_t;
    typedef logic [MOD_BITS-1:0]   mod_t;
    typedef logic [MOD_BITS:0]     mod_wide_t;

    typedef struct packed {
        index_t index_n;
        mod_t   modulus;
    } fm_in_t;

    typedef struct packed {
        mod_t fib_mod;
        logic modulus_error;
    } fm_out_t;

    // request to the modular multiply unit
    typedef struct packed {
        logic start;
        mod_t x;
        mod_t y;
    } mm_req_t;

    // response from the modular multiply unit
    typedef struct packed {
        logic done;
        mod_t prod;
    } mm_rsp_t;

    // (x + y) mod m, valid whenever x + y < 2m
    function automatic mod_t mod_add(mod_t x, mod_t y, mod_t m);
        mod_wide_t s;
        s = {1'b0, x} + {1'b0, y};
        if (s >= {1'b0, m})
        begin
            s = s - {1'b0, m};
        end
        return s[MOD_BITS-1:0];
    endfunction

endpackage

/* rtl/core/fibmod_mulmod.sv */
// ----------------------------------------------------------------------------
// fibmod_mulmod
// Shift-and-add modular multiplier: x * y mod m, one multiplier bit per
// cycle, most significant bit first, accumulator kept below m.
// ----------------------------------------------------------------------------
module fibmod_mulmod (
    input  logic                clk,
    input  logic                rst_n,
    input  fibmod_pkg::mm_req_t req,
    input  fibmod_pkg::mod_t    m,
    output fibmod_pkg::mm_rsp_t rsp
);
    import fibmod_pkg::*;

    logic             busy_reg, busy_next;
    logic             done_reg, done_next;
    logic [CNT_W-1:0] cnt_reg, cnt_next;
    mod_t             acc_reg, acc_next;
    mod_t             x_reg, x_next;
    mod_t             y_reg, y_next;

    mod_wide_t dbl;
    mod_wide_t dbl_red;
    mod_t      acc_step;

    // double then conditionally add x, both reduced by one subtract
    always_comb
    begin
        dbl      = {acc_reg, 1'b0};
        dbl_red  = (dbl >= {1'b0, m}) ? (dbl - {1'b0, m}) : dbl;
        acc_step = y_reg[MOD_BITS-1] ? mod_add(dbl_red[MOD_BITS-1:0], x_reg, m)
                                     : dbl_red[MOD_BITS-1:0];
    end

    always_comb
    begin
        busy_next = busy_reg;
        done_next = 1'b0;
        cnt_next  = cnt_reg;
        acc_next  = acc_reg;
        x_next    = x_reg;
        y_next    = y_reg;
        if (req.start)
        begin
            busy_next = 1'b1;
            cnt_next  = CNT_W'(MOD_BITS - 1);
            acc_next  = '0;
            x_next    = req.x;
            y_next    = req.y;
        end
        else if (busy_reg)
        begin
            acc_next = acc_step;
            y_next   = {y_reg[MOD_BITS-2:0], 1'b0};
            cnt_next = cnt_reg - 1'b1;
            if (cnt_reg == '0)
            begin
                busy_next = 1'b0;
                done_next = 1'b1;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
            cnt_reg  <= '0;
        end
        else
        begin
            busy_reg <= busy_next;
            done_reg <= done_next;
            cnt_reg  <= cnt_next;
        end
    end

    always_ff @(posedge clk)
    begin
        acc_reg <= acc_next;
        x_reg   <= x_next;
        y_reg   <= y_next;
    end

    assign rsp.done = done_reg;
    assign rsp.prod = acc_reg;

    a_no_start_while_busy : assert property (@(posedge clk) disable iff (!rst_n)
        req.start |-> !busy_reg)
        else $error("multiply started while busy");

    a_acc_reduced : assert property (@(posedge clk) disable iff (!rst_n)
        done_reg |-> acc_reg < m)
        else $error("product not reduced below modulus");

    a_done_after_last : assert property (@(posedge clk) disable iff (!rst_n)
        done_reg |-> $past(busy_reg) && !busy_reg)
        else $error("done without a finished multiply");

endmodule

/* rtl/core/fibonacci_modulo.sv */
// ----------------------------------------------------------------------------
// fibonacci_modulo
// F(n) mod m by fast doubling over the bits of n, with all multiplies done
// on one shared shift-and-add modular multiplier.
// ----------------------------------------------------------------------------
// One item at a time: item_stall is high from the accepting transfer until the
// result is loaded into the output register. Leading zero bits of index_n only
// pass through the bit and next states; every bit from the first set bit on runs
// the full doubling step, dominated by three serial modular multiplies at one
// multiplier bit per cycle. A zero modulus returns 0 with modulus_error set. The
// output register lets the next item start while a result waits to be taken.
// ----------------------------------------------------------------------------
module fibonacci_modulo (
    input  logic                clk,
    input  logic                rst_n,
    input  logic                item_valid,
    output logic                item_stall,
    input  fibmod_pkg::fm_in_t  item,
    output logic                result_valid,
    input  logic                result_stall,
    output fibmod_pkg::fm_out_t result
);
    import fibmod_pkg::*;

    localparam logic [3:0] ST_IDLE   = 4'd0;
    localparam logic [3:0] ST_BIT    = 4'd1;
    localparam logic [3:0] ST_TWO_B  = 4'd2;
    localparam logic [3:0] ST_SUB_A  = 4'd3;
    localparam logic [3:0] ST_MUL_C  = 4'd4;
    localparam logic [3:0] ST_MUL_AA = 4'd5;
    localparam logic [3:0] ST_MUL_BB = 4'd6;
    localparam logic [3:0] ST_SUM_D  = 4'd7;
    localparam logic [3:0] ST_UPDATE = 4'd8;
    localparam logic [3:0] ST_NEXT   = 4'd9;
    localparam logic [3:0] ST_FINISH = 4'd10;

    logic [3:0]       state_reg, state_next;
    logic             issued_reg, issued_next;
    logic             started_reg, started_next;
    logic [IDX_W-1:0] bit_reg, bit_next;
    logic             out_valid_reg, out_valid_next;

    index_t  n_reg, n_next;
    mod_t    m_reg, m_next;
    mod_t    a_reg, a_next;
    mod_t    b_reg, b_next;
    mod_t    c_reg, c_next;
    mod_t    d_reg, d_next;
    mod_t    t_reg, t_next;
    logic    err_reg, err_next;
    fm_out_t out_reg, out_next;

    mm_req_t mm_req;
    mm_rsp_t mm_rsp;
    logic    item_xfer;

    assign item_xfer = item_valid && !item_stall;

    fibmod_mulmod u_mulmod (
        .clk   (clk),
        .rst_n (rst_n),
        .req   (mm_req),
        .m     (m_reg),
        .rsp   (mm_rsp)
    );

    always_comb
    begin
        state_next     = state_reg;
        issued_next    = issued_reg;
        started_next   = started_reg;
        bit_next       = bit_reg;
        out_valid_next = out_valid_reg && result_stall;
        n_next         = n_reg;
        m_next         = m_reg;
        a_next         = a_reg;
        b_next         = b_reg;
        c_next         = c_reg;
        d_next         = d_reg;
        t_next         = t_reg;
        err_next       = err_reg;
        out_next       = out_reg;
        mm_req.start   = 1'b0;
        mm_req.x       = a_reg;
        mm_req.y       = a_reg;

        case (state_reg)
            ST_IDLE:
            begin
                if (item_xfer)
                begin
                    n_next       = item.index_n;
                    m_next       = item.modulus;
                    a_next       = '0;
                    b_next       = (item.modulus == mod_t'(1)) ? '0 : mod_t'(1);
                    started_next = 1'b0;
                    bit_next     = IDX_W'(INDEX_BITS - 1);
                    err_next     = (item.modulus == '0);
                    state_next   = (item.modulus == '0) ? ST_FINISH : ST_BIT;
                end
            end
            ST_BIT:
            begin
                // leading zero bits leave the starting pair (0, 1 mod m) unchanged
                if (!started_reg && !n_reg[INDEX_BITS-1])
                begin
                    state_next = ST_NEXT;
                end
                else
                begin
                    started_next = 1'b1;
                    state_next   = ST_TWO_B;
                end
            end
            ST_TWO_B:
            begin
                t_next     = mod_add(b_reg, b_reg, m_reg);
                state_next = ST_SUB_A;
            end
            ST_SUB_A:
            begin
                // t = 2b - a mod m
                t_next     = mod_add(t_reg, m_reg - a_reg, m_reg);
                state_next = ST_MUL_C;
            end
            ST_MUL_C:
            begin
                mm_req.x = a_reg;
                mm_req.y = t_reg;
                if (!issued_reg)
                begin
                    mm_req.start = 1'b1;
                    issued_next  = 1'b1;
                end
                else if (mm_rsp.done)
                begin
                    c_next      = mm_rsp.prod;
                    issued_next = 1'b0;
                    state_next  = ST_MUL_AA;
                end
            end
            ST_MUL_AA:
            begin
                mm_req.x = a_reg;
                mm_req.y = a_reg;
                if (!issued_reg)
                begin
                    mm_req.start = 1'b1;
                    issued_next  = 1'b1;
                end
                else if (mm_rsp.done)
                begin
                    d_next      = mm_rsp.prod;
                    issued_next = 1'b0;
                    state_next  = ST_MUL_BB;
                end
            end
            ST_MUL_BB:
            begin
                mm_req.x = b_reg;
                mm_req.y = b_reg;
                if (!issued_reg)
                begin
                    mm_req.start = 1'b1;
                    issued_next  = 1'b1;
                end
                else if (mm_rsp.done)
                begin
                    t_next      = mm_rsp.prod;
                    issued_next = 1'b0;
                    state_next  = ST_SUM_D;
                end
            end
            ST_SUM_D:
            begin
                d_next     = mod_add(d_reg, t_reg, m_reg);
                state_next = ST_UPDATE;
            end
            ST_UPDATE:
            begin
                if (n_reg[INDEX_BITS-1])
                begin
                    a_next = d_reg;
                    b_next = mod_add(c_reg, d_reg, m_reg);
                end
                else
                begin
                    a_next = c_reg;
                    b_next = d_reg;
                end
                state_next = ST_NEXT;
            end
            ST_NEXT:
            begin
                n_next = {n_reg[INDEX_BITS-2:0], 1'b0};
                if (bit_reg == '0)
                begin
                    state_next = ST_FINISH;
                end
                else
                begin
                    bit_next   = bit_reg - 1'b1;
                    state_next = ST_BIT;
                end
            end
            ST_FINISH:
            begin
                if (!out_valid_reg || !result_stall)
                begin
                    out_next.fib_mod       = err_reg ? '0 : a_reg;
                    out_next.modulus_error = err_reg;
                    out_valid_next         = 1'b1;
                    state_next             = ST_IDLE;
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= ST_IDLE;
            issued_reg    <= 1'b0;
            started_reg   <= 1'b0;
            bit_reg       <= '0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            issued_reg    <= issued_next;
            started_reg   <= started_next;
            bit_reg       <= bit_next;
            out_valid_reg <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        n_reg   <= n_next;
        m_reg   <= m_next;
        a_reg   <= a_next;
        b_reg   <= b_next;
        c_reg   <= c_next;
        d_reg   <= d_next;
        t_reg   <= t_next;
        err_reg <= err_next;
        out_reg <= out_next;
    end

    assign item_stall   = (state_reg != ST_IDLE);
    assign result_valid = out_valid_reg;
    assign result       = out_reg;

    a_pair_reduced : assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg != ST_IDLE && state_reg != ST_FINISH)
            |-> (a_reg < m_reg) && (b_reg < m_reg))
        else $error("fast doubling pair not reduced below modulus");

    a_done_when_issued : assert property (@(posedge clk) disable iff (!rst_n)
        mm_rsp.done |-> issued_reg)
        else $error("multiply response with no request outstanding");

    a_error_result_zero : assert property (@(posedge clk) disable iff (!rst_n)
        (out_valid_reg && out_reg.modulus_error) |-> (out_reg.fib_mod == '0))
        else $error("nonzero result on modulus error");

endmodule

/* tb/fibonacci_modulo_test.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// fibonacci_modulo_test
// Drives (n, m) pairs into the Fibonacci modulo core and checks each returned
// F(n) mod m and error flag against a fast doubling predictor kept here.
// Directed corners first, then random pairs under changing idle rates and one
// long hold on the result side that backs the core up into its input.
// ----------------------------------------------------------------------------
module fibonacci_modulo_test;

    import fibmod_pkg::*;

    localparam int RANDOM_ITEMS = 600;
    localparam int PRESSURE_CYCLES = 8000;
    localparam int DRAIN_CYCLES = 4000;

    class fib_result_board;
        fm_out_t expected_fib[$];
        int      mismatches;

        function new();
            mismatches = 0;
        endfunction

        // F(n) mod m, scanning index bits from the top with (F(k), F(k+1))
        function automatic mod_t fib_mod_predict(index_t n, mod_t m);
            longint unsigned mm;
            longint unsigned fk;
            longint unsigned fk1;
            longint unsigned twice;
            longint unsigned even;
            longint unsigned odd;
            mm  = m;
            fk  = 0;
            fk1 = 1 % mm;
            for (int i = INDEX_BITS - 1; i >= 0; i--)
            begin
                twice = (2 * fk1 + mm - fk) % mm;
                even  = (fk * twice) % mm;
                odd   = ((fk * fk) % mm + (fk1 * fk1) % mm) % mm;
                if (n[i])
                begin
                    fk  = odd;
                    fk1 = (even + odd) % mm;
                end
                else
                begin
                    fk  = even;
                    fk1 = odd;
                end
            end
            return fk[MOD_BITS-1:0];
        endfunction

        function void note_item(fm_in_t v);
            fm_out_t want;
            if (v.modulus == '0)
            begin
                want.fib_mod       = '0;
                want.modulus_error = 1'b1;
            end
            else
            begin
                want.fib_mod       = fib_mod_predict(v.index_n, v.modulus);
                want.modulus_error = 1'b0;
            end
            expected_fib.push_back(want);
        endfunction

        function void check_result(fm_out_t got);
            fm_out_t want;
            if (expected_fib.size() == 0)
            begin
                $error("result with nothing pending: fib_mod %0d modulus_error %0b",
                       got.fib_mod, got.modulus_error);
                mismatches++;
                return;
            end
            want = expected_fib.pop_front();
            if (got.fib_mod !== want.fib_mod)
            begin
                $error("fib_mod expected %0d actual %0d", want.fib_mod, got.fib_mod);
                mismatches++;
            end
            if (got.modulus_error !== want.modulus_error)
            begin
                $error("modulus_error expected %0b actual %0b",
                       want.modulus_error, got.modulus_error);
                mismatches++;
            end
        endfunction

        function int pending();
            return expected_fib.size();
        endfunction
    endclass

    logic    clk;
    logic    rst_n;
    logic    item_valid;
    logic    item_stall;
    fm_in_t  item;
    logic    result_valid;
    logic    result_stall;
    fm_out_t result;

    fib_result_board board;

    int   tx_idle_pct;
    int   rx_idle_pct;
    logic pressure_go;

    fibonacci_modulo i_dut (
        .clk          (clk),
        .rst_n        (rst_n),
        .item_valid   (item_valid),
        .item_stall   (item_stall),
        .item         (item),
        .result_valid (result_valid),
        .result_stall (result_stall),
        .result       (result)
    );

    initial
    begin
        clk = 1'b0;
        forever
        begin
            #10 clk = ~clk;
        end
    end

    initial
    begin
        #200_000_000;
        $display("fibonacci_modulo_test NOT OK");
        $finish;
    end

    // result side: random stalls, plus one long hold once pressure_go rises
    initial
    begin
        int  hold_left;
        bit  pressure_done;
        hold_left     = 0;
        pressure_done = 1'b0;
        result_stall  = 1'b0;
        forever
        begin
            @(posedge clk);
            if (hold_left > 0)
            begin
                hold_left--;
                result_stall <= 1'b1;
            end
            else if (pressure_go && !pressure_done)
            begin
                pressure_done = 1'b1;
                hold_left     = PRESSURE_CYCLES;
                result_stall <= 1'b1;
            end
            else
            begin
                result_stall <= ($urandom_range(0, 99) < rx_idle_pct);
            end
        end
    end

    always @(posedge clk)
    begin
        if (rst_n && result_valid && !result_stall)
        begin
            board.check_result(result);
        end
    end

    task automatic send_item(input fm_in_t v);
        while ($urandom_range(0, 99) < tx_idle_pct)
        begin
            item_valid <= 1'b0;
            @(posedge clk);
        end
        item_valid <= 1'b1;
        item       <= v;
        @(posedge clk);
        while (item_stall)
        begin
            @(posedge clk);
        end
        board.note_item(v);
    endtask

    // mostly short indexes to keep the run short, some full width
    function automatic fm_in_t random_item();
        fm_in_t          v;
        logic [63:0]     raw;
        int              len;
        int              pick;
        raw  = {$urandom(), $urandom()};
        len  = ($urandom_range(0, 99) < 15) ? INDEX_BITS : $urandom_range(0, 16);
        v.index_n = raw[INDEX_BITS-1:0];
        if (len < INDEX_BITS)
        begin
            v.index_n = v.index_n & ((index_t'(1) << len) - 1);
        end
        pick = $urandom_range(0, 99);
        if (pick < 3)
        begin
            v.modulus = '0;
        end
        else if (pick < 15)
        begin
            v.modulus = mod_t'($urandom_range(1, 16));
        end
        else
        begin
            v.modulus = mod_t'($urandom_range(1, (1 << MOD_BITS) - 1));
        end
        return v;
    endfunction

    task automatic send_pair(input index_t n, input mod_t m);
        fm_in_t v;
        v.index_n = n;
        v.modulus = m;
        send_item(v);
    endtask

    initial
    begin
        index_t n_max;
        mod_t   m_max;
        n_max        = '1;
        m_max        = '1;
        board        = new();
        rst_n        = 1'b0;
        item_valid   = 1'b0;
        item         = '0;
        tx_idle_pct  = 9;
        rx_idle_pct  = 79;
        pressure_go  = 1'b0;
        repeat (7) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // zero modulus, modulus one, small indexes, field extremes
        send_pair('0, '0);
        send_pair(n_max, '0);
        send_pair('0, 20'd1);
        send_pair(n_max, 20'd1);
        send_pair(48'd1, 20'd1);
        send_pair('0, 20'd7);
        send_pair(48'd1, 20'd7);
        send_pair(48'd2, 20'd7);
        send_pair(48'd1, m_max);
        send_pair(48'd10, m_max);
        send_pair(48'd30, m_max);
        send_pair(n_max, m_max);
        send_pair(n_max, 20'd2);
        send_pair(48'h8000_0000_0000, 20'd999983);
        send_pair(48'haaaa_aaaa_aaaa, 20'h55555);
        send_pair(48'h5555_5555_5555, 20'haaaaa);
        send_pair(48'd12345, 20'd2);
        send_pair(48'd100, 20'd3);
        send_pair(48'd60, 20'd10);
        send_pair(48'd1, 20'h80000);

        for (int k = 0; k < RANDOM_ITEMS; k++)
        begin
            if (k == RANDOM_ITEMS / 3)
            begin
                tx_idle_pct = 79;
                rx_idle_pct = 9;
            end
            else if (k == 2 * RANDOM_ITEMS / 3)
            begin
                tx_idle_pct = 0;
                rx_idle_pct = 0;
                pressure_go <= 1'b1;
            end
            send_item(random_item());
        end
        item_valid <= 1'b0;

        while (board.pending() != 0)
        begin
            @(posedge clk);
        end
        repeat (DRAIN_CYCLES) @(posedge clk);

        if (board.mismatches == 0 && board.pending() == 0)
        begin
            $display("fibonacci_modulo_test OK");
        end
        else
        begin
            $display("fibonacci_modulo_test NOT OK");
        end
        $finish;
    end

endmodule
